// File: sv/uer_pkg.sv
// Shared types, codes and reset constants for the ultrasonic echo ranger.
package uer_pkg;

    // Default sizing
    localparam int RING_DEPTH_DEF  = 16;
    localparam int TIMER_WIDTH_DEF = 16;

    // Field and port widths
    localparam int WIDTH_W  = 16;
    localparam int FUNC_W   = 3;
    localparam int MODE_W   = 3;
    localparam int TLEN_W   = 8;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 16;

    // Register reset values
    localparam logic [WIDTH_W-1:0] THRESHOLD_RST = 16'd0;
    localparam logic [WIDTH_W-1:0] MAX_ECHO_RST  = 16'd32768;
    localparam logic [TLEN_W-1:0]  TRIG_LEN_RST  = 8'd10;
    localparam logic [WIDTH_W-1:0] REBOOT_RST    = 16'hFFFF;

    // Saturation point of the trigger pulse tick counter
    localparam logic [TLEN_W-1:0]  TRIG_TICKS_MAX = 8'hFF;

    // Sensor modes
    typedef enum logic [MODE_W-1:0] {
        MD_OFF     = 3'd0,
        MD_IDLE    = 3'd1,
        MD_TRIGGER = 3'd2,
        MD_CAPTURE = 3'd3,
        MD_REBOOT  = 3'd4
    } t_mode;

    // Input function codes
    typedef enum logic [FUNC_W-1:0] {
        FN_TICK       = 3'd0,
        FN_ENABLE     = 3'd1,
        FN_ENABLE_RB  = 3'd2,
        FN_DISABLE    = 3'd3,
        FN_REBOOT     = 3'd4
    } t_func;

    // Configuration register indexes
    typedef enum logic [CFG_AW-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_MAX_ECHO  = 2'd1,
        CFG_TRIG_LEN  = 2'd2,
        CFG_REBOOT    = 2'd3
    } t_cfg_idx;

    // Configuration seen by the mode controller
    typedef struct packed {
        logic [WIDTH_W-1:0] max_echo;
        logic [TLEN_W-1:0]  trig_len;
        logic [WIDTH_W-1:0] reboot_delay;
    } t_ctrl_cfg;

    // Per-item status from the mode controller
    typedef struct packed {
        t_mode              mode;
        logic               trig;
        logic               smp_vld;
        logic [WIDTH_W-1:0] smp_width;
    } t_ctrl_stat;

    // Sequencer states
    typedef enum logic [1:0] {
        SQ_IDLE = 2'd0,
        SQ_SCAN = 2'd1,
        SQ_LAST = 2'd2,
        SQ_DONE = 2'd3
    } t_seq;

endpackage

// File: sv/uer_ram.sv
// Generic single-write, single-read RAM with registered read data.
module uer_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/uer_ctrl.sv
// Mode, timer, trigger and echo capture controller; one update per transfer.
module uer_ctrl #(
    parameter int RING_DEPTH  = uer_pkg::RING_DEPTH_DEF,
    parameter int TIMER_WIDTH = uer_pkg::TIMER_WIDTH_DEF,
    parameter int SW          = $clog2(RING_DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_acc,
    input  logic [uer_pkg::FUNC_W-1:0]    i_func,
    input  logic                          i_echo_level,
    input  uer_pkg::t_ctrl_cfg            i_cfg,
    output uer_pkg::t_ctrl_stat           o_stat,
    output logic                          o_wr_en,
    output logic [SW-1:0]                 o_wr_addr,
    output logic [uer_pkg::WIDTH_W-1:0]   o_wr_data
);

    localparam int TW = TIMER_WIDTH;
    localparam int CW = (TW > uer_pkg::WIDTH_W) ? TW : uer_pkg::WIDTH_W;

    uer_pkg::t_mode                r_mode, n_mode;
    logic [TW-1:0]                 r_timer, n_timer;
    logic [TW-1:0]                 r_cap, n_cap;
    logic [SW-1:0]                 r_slot, n_slot;
    logic                          r_prev, n_prev;
    logic                          r_trig, n_trig;
    logic [uer_pkg::TLEN_W-1:0]    r_tt, n_tt;
    logic                          r_sv, n_sv;
    logic [uer_pkg::WIDTH_W-1:0]   r_sw, n_sw;

    logic [TW-1:0]                 rld_max;
    logic [TW-1:0]                 rld_rbd;
    logic [TW-1:0]                 adv;
    logic [TW-1:0]                 w_raw;
    logic [CW-1:0]                 w_ext;
    logic [CW-1:0]                 max_ext;
    logic [uer_pkg::TLEN_W-1:0]    tt_inc;
    logic                          rise;
    logic                          fall;
    logic                          rec;

    // Reload values kept modulo the timer width
    assign rld_max = TW'(i_cfg.max_echo);
    assign rld_rbd = TW'(i_cfg.reboot_delay);

    // Timer advance with wrap at the reload value
    assign adv = (r_timer >= rld_max) ? '0 : r_timer + 1'b1;

    // Echo width candidate, zero when the timer is not past the start
    assign w_raw   = (adv > r_cap) ? adv - r_cap : '0;
    assign w_ext   = CW'(w_raw);
    assign max_ext = CW'(i_cfg.max_echo);

    assign tt_inc = (r_tt != uer_pkg::TRIG_TICKS_MAX) ? r_tt + 1'b1 : r_tt;
    assign rise   = !r_prev && i_echo_level;
    assign fall   = r_prev && !i_echo_level;

    // Next state for one item
    always_comb begin
        n_mode  = r_mode;
        n_timer = r_timer;
        n_cap   = r_cap;
        n_slot  = r_slot;
        n_prev  = r_prev;
        n_trig  = r_trig;
        n_tt    = r_tt;
        n_sv    = 1'b0;
        n_sw    = '0;
        rec     = 1'b0;
        case (uer_pkg::t_func'(i_func))
            uer_pkg::FN_TICK: begin
                n_prev = i_echo_level;
                if (r_mode == uer_pkg::MD_REBOOT) begin
                    if (r_timer >= rld_rbd) begin
                        n_mode  = uer_pkg::MD_IDLE;
                        n_trig  = 1'b0;
                        n_timer = '0;
                    end else begin
                        n_timer = r_timer + 1'b1;
                    end
                end else if (r_mode != uer_pkg::MD_OFF) begin
                    n_timer = adv;
                    case (r_mode)
                        uer_pkg::MD_IDLE: begin
                            if (adv >= rld_max) begin
                                n_timer = '0;
                                n_mode  = uer_pkg::MD_TRIGGER;
                                n_trig  = 1'b1;
                                n_tt    = '0;
                            end
                        end
                        uer_pkg::MD_TRIGGER: begin
                            if (r_trig) begin
                                n_tt = tt_inc;
                                if (tt_inc >= i_cfg.trig_len) begin
                                    n_trig = 1'b0;
                                end
                            end
                            if (rise) begin
                                n_trig = 1'b0;
                                n_mode = uer_pkg::MD_CAPTURE;
                                n_cap  = adv;
                            end
                        end
                        uer_pkg::MD_CAPTURE: begin
                            if (fall) begin
                                rec    = 1'b1;
                                n_sv   = 1'b1;
                                n_sw   = (w_ext > max_ext) ? '0 : w_ext[uer_pkg::WIDTH_W-1:0];
                                n_mode = uer_pkg::MD_IDLE;
                                n_slot = (r_slot == SW'(RING_DEPTH - 1)) ? '0 : r_slot + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            uer_pkg::FN_ENABLE, uer_pkg::FN_ENABLE_RB: begin
                if (r_mode == uer_pkg::MD_OFF ||
                    (i_func == uer_pkg::FN_ENABLE_RB && r_mode == uer_pkg::MD_REBOOT)) begin
                    n_timer = '0;
                    n_mode  = uer_pkg::MD_IDLE;
                    n_trig  = 1'b0;
                end
            end
            uer_pkg::FN_DISABLE: begin
                if (r_mode != uer_pkg::MD_OFF) begin
                    n_mode = uer_pkg::MD_OFF;
                    n_trig = 1'b0;
                end
            end
            uer_pkg::FN_REBOOT: begin
                if (r_mode != uer_pkg::MD_REBOOT) begin
                    n_timer = '0;
                    n_mode  = uer_pkg::MD_REBOOT;
                    n_trig  = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // State registers, updated on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= uer_pkg::MD_OFF;
            r_timer <= '0;
            r_cap   <= '0;
            r_slot  <= '0;
            r_prev  <= 1'b0;
            r_trig  <= 1'b0;
            r_tt    <= '0;
            r_sv    <= 1'b0;
            r_sw    <= '0;
        end else if (i_acc) begin
            r_mode  <= n_mode;
            r_timer <= n_timer;
            r_cap   <= n_cap;
            r_slot  <= n_slot;
            r_prev  <= n_prev;
            r_trig  <= n_trig;
            r_tt    <= n_tt;
            r_sv    <= n_sv;
            r_sw    <= n_sw;
        end
    end

    // Ring write for a recorded width
    assign o_wr_en   = i_acc && rec;
    assign o_wr_addr = r_slot;
    assign o_wr_data = n_sw;

    assign o_stat.mode      = r_mode;
    assign o_stat.trig      = r_trig;
    assign o_stat.smp_vld   = r_sv;
    assign o_stat.smp_width = r_sw;

endmodule

// File: sv/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: config, ring scan and result register.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one item per transfer: i_func selects
//   a microsecond tick (with the sampled i_echo_level) or a command. Output channel
//   (o_valid / i_stall) returns exactly one result per item: near flag, mode,
//   trigger pin level and any echo width recorded by that item.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while the
//   block has no item in flight; writes take effect at once.
// Timing:
//   After an input transfer the echo width ring is scanned through the single read
//   port of its RAM, one entry per cycle; the sequencer then passes through its last
//   and done states, and the result is loaded into the output register from done.
//   The next item is taken once the result has moved into the output register, so
//   a new item is not accepted while one is still in flight.
// Reset:
//   Synchronous, active low. Mode off, timer and capture cleared, and every ring
//   entry reads as zero until written (per-entry valid bits cleared at reset).
// Stall:
//   A stalled result holds steady in the output register; the scan of the next
//   item may not finish into it until the pending result has been transferred.
module ultrasonic_echo_ranger #(
    parameter int RING_DEPTH  = uer_pkg::RING_DEPTH_DEF,
    parameter int TIMER_WIDTH = uer_pkg::TIMER_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [uer_pkg::FUNC_W-1:0]    i_func,
    input  logic                          i_echo_level,
    // output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_near_flag,
    output logic [uer_pkg::MODE_W-1:0]    o_sensor_mode,
    output logic                          o_trig_out,
    output logic                          o_sample_valid,
    output logic [uer_pkg::WIDTH_W-1:0]   o_sample_width,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [uer_pkg::CFG_AW-1:0]    i_cfg_idx,
    input  logic [uer_pkg::CFG_DW-1:0]    i_cfg_data
);

    localparam int AW = $clog2(RING_DEPTH);

    // Configuration registers
    logic [uer_pkg::WIDTH_W-1:0]   r_thr;
    logic [uer_pkg::WIDTH_W-1:0]   r_max;
    logic [uer_pkg::TLEN_W-1:0]    r_tlen;
    logic [uer_pkg::WIDTH_W-1:0]   r_rbd;
    uer_pkg::t_ctrl_cfg            ctrl_cfg;

    // Sequencer and scan
    uer_pkg::t_seq                 r_seq, n_seq;
    logic [AW-1:0]                 r_addr;
    logic [AW-1:0]                 r_pidx;
    logic                          r_pend;
    logic                          r_near;
    logic [RING_DEPTH-1:0]         r_vld;
    logic                          in_acc;
    logic                          scan_rd;
    logic                          scan_end;
    logic                          out_free;
    logic                          out_load;
    logic                          hit;
    logic [uer_pkg::WIDTH_W-1:0]   rd_data;
    logic [uer_pkg::WIDTH_W-1:0]   rd_val;

    // Controller interface
    uer_pkg::t_ctrl_stat           stat;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [uer_pkg::WIDTH_W-1:0]   wr_data;

    // Output register
    logic                          r_oval;
    logic                          r_onear;
    logic [uer_pkg::MODE_W-1:0]    r_omode;
    logic                          r_otrig;
    logic                          r_osv;
    logic [uer_pkg::WIDTH_W-1:0]   r_osw;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= uer_pkg::THRESHOLD_RST;
            r_max  <= uer_pkg::MAX_ECHO_RST;
            r_tlen <= uer_pkg::TRIG_LEN_RST;
            r_rbd  <= uer_pkg::REBOOT_RST;
        end else if (i_cfg_we) begin
            case (uer_pkg::t_cfg_idx'(i_cfg_idx))
                uer_pkg::CFG_THRESHOLD: r_thr  <= i_cfg_data;
                uer_pkg::CFG_MAX_ECHO:  r_max  <= i_cfg_data;
                uer_pkg::CFG_TRIG_LEN:  r_tlen <= i_cfg_data[uer_pkg::TLEN_W-1:0];
                uer_pkg::CFG_REBOOT:    r_rbd  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign ctrl_cfg.max_echo     = r_max;
    assign ctrl_cfg.trig_len     = r_tlen;
    assign ctrl_cfg.reboot_delay = r_rbd;

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_oval || !i_stall;
    assign scan_end = (r_addr == AW'(RING_DEPTH - 1));

    uer_ctrl #(
        .RING_DEPTH  (RING_DEPTH),
        .TIMER_WIDTH (TIMER_WIDTH),
        .SW          (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (in_acc),
        .i_func       (i_func),
        .i_echo_level (i_echo_level),
        .i_cfg        (ctrl_cfg),
        .o_stat       (stat),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data)
    );

    uer_ram #(
        .WIDTH (uer_pkg::WIDTH_W),
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (scan_rd),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    // Sequencer next state
    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            uer_pkg::SQ_IDLE: if (in_acc)   n_seq = uer_pkg::SQ_SCAN;
            uer_pkg::SQ_SCAN: if (scan_end) n_seq = uer_pkg::SQ_LAST;
            uer_pkg::SQ_LAST: n_seq = uer_pkg::SQ_DONE;
            uer_pkg::SQ_DONE: if (out_free) n_seq = uer_pkg::SQ_IDLE;
            default: n_seq = uer_pkg::SQ_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_stall  = 1'b1;
        scan_rd  = 1'b0;
        out_load = 1'b0;
        case (r_seq)
            uer_pkg::SQ_IDLE: o_stall  = 1'b0;
            uer_pkg::SQ_SCAN: scan_rd  = 1'b1;
            uer_pkg::SQ_LAST: ;
            uer_pkg::SQ_DONE: out_load = out_free;
            default: ;
        endcase
    end

    // Unwritten entries read as zero
    assign rd_val = r_vld[r_pidx] ? rd_data : '0;
    assign hit    = (rd_val <= r_thr);

    // Scan address, read tracking and near accumulation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq  <= uer_pkg::SQ_IDLE;
            r_addr <= '0;
            r_pidx <= '0;
            r_pend <= 1'b0;
            r_near <= 1'b0;
        end else begin
            r_seq  <= n_seq;
            r_pend <= scan_rd;
            r_pidx <= r_addr;
            if (in_acc) begin
                r_addr <= '0;
                r_near <= 1'b0;
            end else begin
                if (scan_rd && !scan_end) begin
                    r_addr <= r_addr + 1'b1;
                end
                if (r_pend && hit) begin
                    r_near <= 1'b1;
                end
            end
        end
    end

    // Entry valid bits, set on first write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (out_load) begin
            r_oval <= 1'b1;
        end else if (!i_stall) begin
            r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_onear <= r_near || (stat.mode == uer_pkg::MD_OFF);
            r_omode <= stat.mode;
            r_otrig <= stat.trig;
            r_osv   <= stat.smp_vld;
            r_osw   <= stat.smp_width;
        end
    end

    assign o_valid        = r_oval;
    assign o_near_flag    = r_onear;
    assign o_sensor_mode  = r_omode;
    assign o_trig_out     = r_otrig;
    assign o_sample_valid = r_osv;
    assign o_sample_width = r_osw;

endmodule

// File: sv/uer_chk.sv
// Port-level checker for the ultrasonic echo ranger, bound to the top level.
module uer_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_stall,
    input  logic                          o_valid,
    input  logic                          i_stall,
    input  logic                          o_near_flag,
    input  logic [uer_pkg::MODE_W-1:0]    o_sensor_mode,
    input  logic                          o_trig_out,
    input  logic                          o_sample_valid,
    input  logic [uer_pkg::WIDTH_W-1:0]   o_sample_width
);

    // An input transfer starts the ring scan, so the input side stalls next cycle
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after transfer");

    // The mode off always reports near
    a_off_near: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sensor_mode == uer_pkg::MD_OFF) |-> o_near_flag)
        else $error("off mode without near flag");

    // A recorded width ends the capture and returns to idle
    a_sample_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sample_valid) |-> (o_sensor_mode == uer_pkg::MD_IDLE))
        else $error("sample reported outside idle");

    // The trigger pin is only driven in trigger mode
    a_trig_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_trig_out) |-> (o_sensor_mode == uer_pkg::MD_TRIGGER))
        else $error("trigger high outside trigger mode");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_near_flag) &&
            $stable(o_sensor_mode) && $stable(o_trig_out) &&
            $stable(o_sample_valid) && $stable(o_sample_width)))
        else $error("stalled result changed");

endmodule

bind ultrasonic_echo_ranger uer_chk u_uer_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_near_flag    (o_near_flag),
    .o_sensor_mode  (o_sensor_mode),
    .o_trig_out     (o_trig_out),
    .o_sample_valid (o_sample_valid),
    .o_sample_width (o_sample_width)
);

// File: bench/ultrasonic_echo_ranger_tb.sv
// Self-checking testbench for the ultrasonic echo ranger: directed and random transfers.
module ultrasonic_echo_ranger_tb;

    import uer_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int RING_SIZE      = RING_DEPTH_DEF;

    // Codes outside the defined function set
    localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 3'd7;

    // One result as seen on the output channel
    typedef struct packed {
        logic               near;
        t_mode              mode;
        logic               trig;
        logic               svld;
        logic [WIDTH_W-1:0] swidth;
    } t_ranger_status;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [FUNC_W-1:0]    i_func;
    logic                 i_echo_level;
    logic                 o_valid;
    logic                 i_stall;
    logic                 o_near_flag;
    logic [MODE_W-1:0]    o_sensor_mode;
    logic                 o_trig_out;
    logic                 o_sample_valid;
    logic [WIDTH_W-1:0]   o_sample_width;
    logic                 i_cfg_we;
    logic [CFG_AW-1:0]    i_cfg_idx;
    logic [CFG_DW-1:0]    i_cfg_data;

    t_ranger_status expected_status_q[$];
    int             mismatches    = 0;
    int             quiet_cycles  = 0;
    int             items_sent    = 0;
    int             sender_gap_pct = 0;
    int             recv_stall_pct = 0;

    // Register copies
    logic [WIDTH_W-1:0] cfg_threshold;
    logic [WIDTH_W-1:0] cfg_max_echo;
    logic [TLEN_W-1:0]  cfg_trig_len;
    logic [WIDTH_W-1:0] cfg_reboot;

    // Predicted sensor state
    t_mode              mdl_mode;
    logic [WIDTH_W-1:0] mdl_timer;
    logic [WIDTH_W-1:0] mdl_cap_start;
    logic [WIDTH_W-1:0] mdl_ring [RING_SIZE];
    int                 mdl_slot;
    logic               mdl_prev_echo;
    logic               mdl_trig;
    logic [TLEN_W-1:0]  mdl_trig_ticks;

    ultrasonic_echo_ranger dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_echo_level   (i_echo_level),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_near_flag    (o_near_flag),
        .o_sensor_mode  (o_sensor_mode),
        .o_trig_out     (o_trig_out),
        .o_sample_valid (o_sample_valid),
        .o_sample_width (o_sample_width),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Sensor predictor
    // ------------------------------------------------------------------
    task automatic reset_ranger_state();
        cfg_threshold  = THRESHOLD_RST;
        cfg_max_echo   = MAX_ECHO_RST;
        cfg_trig_len   = TRIG_LEN_RST;
        cfg_reboot     = REBOOT_RST;
        mdl_mode       = MD_OFF;
        mdl_timer      = '0;
        mdl_cap_start  = '0;
        mdl_slot       = 0;
        mdl_prev_echo  = 1'b0;
        mdl_trig       = 1'b0;
        mdl_trig_ticks = '0;
        for (int k = 0; k < RING_SIZE; k++) mdl_ring[k] = '0;
    endtask

    function automatic t_ranger_status step_ranger(input logic [FUNC_W-1:0] fn, input logic lvl);
        t_ranger_status     res;
        logic               rise;
        logic               fall;
        logic [WIDTH_W-1:0] w;
        res = '0;
        case (fn)
            FN_TICK: begin
                rise = !mdl_prev_echo && lvl;
                fall = mdl_prev_echo && !lvl;
                mdl_prev_echo = lvl;
                if (mdl_mode == MD_REBOOT) begin
                    // reboot ends once the timer has reached the delay
                    if (mdl_timer >= cfg_reboot) begin
                        mdl_mode  = MD_IDLE;
                        mdl_trig  = 1'b0;
                        mdl_timer = '0;
                    end else begin
                        mdl_timer = mdl_timer + 1'b1;
                    end
                end else if (mdl_mode != MD_OFF) begin
                    mdl_timer = (mdl_timer >= cfg_max_echo) ? '0 : mdl_timer + 1'b1;
                    case (mdl_mode)
                        MD_IDLE: begin
                            // cooldown over: start a trigger pulse
                            if (mdl_timer >= cfg_max_echo) begin
                                mdl_timer      = '0;
                                mdl_mode       = MD_TRIGGER;
                                mdl_trig       = 1'b1;
                                mdl_trig_ticks = '0;
                            end
                        end
                        MD_TRIGGER: begin
                            if (mdl_trig) begin
                                if (mdl_trig_ticks != TRIG_TICKS_MAX)
                                    mdl_trig_ticks = mdl_trig_ticks + 1'b1;
                                if (mdl_trig_ticks >= cfg_trig_len) mdl_trig = 1'b0;
                            end
                            if (rise) begin
                                mdl_trig      = 1'b0;
                                mdl_mode      = MD_CAPTURE;
                                mdl_cap_start = mdl_timer;
                            end
                        end
                        MD_CAPTURE: begin
                            if (fall) begin
                                w = (mdl_timer > mdl_cap_start) ? mdl_timer - mdl_cap_start : '0;
                                if (w > cfg_max_echo) w = '0;
                                mdl_ring[mdl_slot] = w;
                                mdl_slot   = (mdl_slot + 1) % RING_SIZE;
                                res.svld   = 1'b1;
                                res.swidth = w;
                                mdl_mode   = MD_IDLE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            FN_ENABLE, FN_ENABLE_RB: begin
                if (mdl_mode == MD_OFF || (fn == FN_ENABLE_RB && mdl_mode == MD_REBOOT)) begin
                    mdl_timer = '0;
                    mdl_mode  = MD_IDLE;
                    mdl_trig  = 1'b0;
                end
            end
            FN_DISABLE: begin
                if (mdl_mode != MD_OFF) begin
                    mdl_mode = MD_OFF;
                    mdl_trig = 1'b0;
                end
            end
            FN_REBOOT: begin
                if (mdl_mode != MD_REBOOT) begin
                    mdl_timer = '0;
                    mdl_mode  = MD_REBOOT;
                    mdl_trig  = 1'b0;
                end
            end
            default: ;
        endcase
        // near when off or any stored width is within the threshold
        res.near = (mdl_mode == MD_OFF);
        for (int k = 0; k < RING_SIZE; k++)
            if (mdl_ring[k] <= cfg_threshold) res.near = 1'b1;
        res.mode = mdl_mode;
        res.trig = mdl_trig;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch on %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_ranger_status want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_status_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result transfer with nothing expected: mode %0d", o_sensor_mode);
            end else begin
                want = expected_status_q.pop_front();
                check_field("near_flag", want.near, o_near_flag);
                check_field("sensor_mode", want.mode, o_sensor_mode);
                check_field("trig_out", want.trig, o_trig_out);
                check_field("sample_valid", want.svld, o_sample_valid);
                check_field("sample_width", want.swidth, o_sample_width);
            end
        end
    end

    // Receiver stalls at random
    always @(negedge i_clk)
        i_stall <= ($urandom_range(99) < recv_stall_pct);

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_item(input logic [FUNC_W-1:0] fn, input logic lvl);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_func       <= fn;
        i_echo_level <= lvl;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_status_q.push_back(step_ranger(fn, lvl));
        if (fn <= FN_REBOOT) items_sent++;
    endtask

    // Hold off the sender until every expected result has arrived
    task automatic wait_results_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_status_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DW-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
    endtask

    task automatic apply_config(input logic [WIDTH_W-1:0] th, input logic [WIDTH_W-1:0] me,
                                input logic [TLEN_W-1:0] tl, input logic [WIDTH_W-1:0] rb);
        write_reg(CFG_THRESHOLD, th);
        write_reg(CFG_MAX_ECHO, me);
        write_reg(CFG_TRIG_LEN, {{(CFG_DW-TLEN_W){1'b0}}, tl});
        write_reg(CFG_REBOOT, rb);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_threshold = th;
        cfg_max_echo  = me;
        cfg_trig_len  = tl;
        cfg_reboot    = rb;
    endtask

    // Quiet ticks until the predicted mode is reached, bounded
    task automatic wait_for_mode(input t_mode target, input int max_ticks);
        int n;
        n = 0;
        while (mdl_mode != target && n < max_ticks) begin
            send_item(FN_TICK, 1'b0);
            n++;
        end
    endtask

    // Full measurement: cooldown, trigger, echo pulse; sometimes cut short by a command
    task automatic run_echo_cycle();
        int unsigned hi;
        int unsigned w;
        int unsigned lead;
        int unsigned k;
        bit          cut;
        case (mdl_mode)
            MD_OFF:    send_item(FN_ENABLE, 1'b0);
            MD_REBOOT: send_item(FN_ENABLE_RB, 1'b0);
            MD_CAPTURE: begin
                if (!mdl_prev_echo) send_item(FN_TICK, 1'b1);
                send_item(FN_TICK, 1'b0);
            end
            default: ;
        endcase
        wait_for_mode(MD_TRIGGER, 64);
        if (mdl_mode != MD_TRIGGER) return;
        lead = $urandom_range(3);
        if (mdl_prev_echo && lead == 0) lead = 1;
        repeat (lead) send_item(FN_TICK, 1'b0);
        hi = (cfg_max_echo > 36) ? 40 : cfg_max_echo + 4;
        w = $urandom_range(1) ? $urandom_range(1, hi) : $urandom_range(1, (hi + 1) / 2);
        cut = ($urandom_range(7) == 0);
        for (k = 0; k < w; k++) begin
            if (cut && k == w / 2) begin
                send_item(FUNC_W'($urandom_range(FN_ENABLE, FN_REBOOT)),
                          1'($urandom_range(1)));
                return;
            end
            send_item(FN_TICK, 1'b1);
        end
        send_item(FN_TICK, 1'b0);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4))
            send_item(FUNC_W'($urandom_range(FN_UNUSED_HI)), 1'($urandom_range(1)));
    endtask

    task automatic apply_random_config();
        logic [WIDTH_W-1:0] th;
        logic [WIDTH_W-1:0] me;
        logic [TLEN_W-1:0]  tl;
        logic [WIDTH_W-1:0] rb;
        case ($urandom_range(11))
            0:       me = '0;
            1:       me = '1;
            default: me = WIDTH_W'($urandom_range(1, 24));
        endcase
        case ($urandom_range(3))
            0:       th = '0;
            1:       th = WIDTH_W'($urandom_range(16'hFFFF));
            default: th = WIDTH_W'($urandom_range(0, (me > 24) ? 24 : me));
        endcase
        case ($urandom_range(7))
            0:       tl = '0;
            1:       tl = '1;
            2:       tl = TLEN_W'($urandom_range(255));
            default: tl = TLEN_W'($urandom_range(1, 8));
        endcase
        case ($urandom_range(9))
            0:       rb = '0;
            1:       rb = '1;
            default: rb = WIDTH_W'($urandom_range(1, 30));
        endcase
        apply_config(th, me, tl, rb);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Off after reset: ticks and unused codes leave the mode alone
    task automatic test_power_up();
        send_item(FN_TICK, 1'b1);
        send_item(FN_UNUSED_LO, 1'b0);
        send_item(FN_UNUSED_HI, 1'b1);
        send_item(FN_DISABLE, 1'b0);
    endtask

    // Each command where it applies and where it is ignored
    task automatic test_commands();
        send_item(FN_ENABLE, 1'b0);
        send_item(FN_ENABLE, 1'b0);
        send_item(FN_REBOOT, 1'b0);
        send_item(FN_REBOOT, 1'b0);
        send_item(FN_ENABLE, 1'b0);
        send_item(FN_ENABLE_RB, 1'b0);
        send_item(FN_DISABLE, 1'b0);
        send_item(FN_ENABLE_RB, 1'b0);
    endtask

    // Trigger pulse, capture, reboot expiry and a width lost to the timer wrap
    task automatic test_echo_edges();
        wait_results_drained();
        apply_config('1, 16'd3, 8'd0, 16'd1);
        wait_for_mode(MD_TRIGGER, 8);
        send_item(FN_TICK, 1'b0);   // zero pulse length drops after one tick
        send_item(FN_TICK, 1'b1);   // rising edge opens the capture
        send_item(FN_TICK, 1'b1);
        send_item(FN_TICK, 1'b0);   // falling edge records the width
        send_item(FN_REBOOT, 1'b0);
        wait_for_mode(MD_IDLE, 4);
        wait_results_drained();
        apply_config('0, 16'd3, 8'd200, 16'd1);
        wait_for_mode(MD_TRIGGER, 8);
        send_item(FN_TICK, 1'b1);   // echo cuts the long pulse at once
        repeat (2) send_item(FN_TICK, 1'b1);
        send_item(FN_TICK, 1'b0);   // timer wrapped below the capture start
    endtask

    // Zero cooldown and zero reboot delay
    task automatic test_zero_max_echo();
        wait_results_drained();
        apply_config('0, '0, 8'd1, '0);
        send_item(FN_TICK, 1'b0);
        send_item(FN_TICK, 1'b1);
        send_item(FN_TICK, 1'b0);
        send_item(FN_REBOOT, 1'b0);
        send_item(FN_TICK, 1'b0);
    endtask

    task automatic test_register_extremes();
        wait_results_drained();
        apply_config('1, '1, '1, '1);
        send_item(FN_TICK, 1'b1);
        send_item(FN_TICK, 1'b0);
        send_item(FN_REBOOT, 1'b0);
        send_item(FN_TICK, 1'b0);
        send_item(FN_DISABLE, 1'b0);
    endtask

    // Mostly measurement cycles, with noise and new settings every so often
    task automatic test_random_traffic(input int gap_pct, input int stall_pct, input int n_target);
        int first;
        int next_cfg;
        sender_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        first    = items_sent;
        next_cfg = 0;
        while (items_sent - first < n_target) begin
            if (items_sent - first >= next_cfg) begin
                wait_results_drained();
                apply_random_config();
                next_cfg += 140;
            end
            case ($urandom_range(9))
                0, 1:    send_noise();
                2:       send_item(FN_TICK, 1'($urandom_range(1)));
                default: run_echo_cycle();
            endcase
        end
    endtask

    initial begin
        reset_ranger_state();
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_func       = FN_TICK;
        i_echo_level = 1'b0;
        i_stall      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_THRESHOLD;
        i_cfg_data   = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        sender_gap_pct = 12;
        recv_stall_pct = 83;
        test_power_up();
        test_commands();
        test_echo_edges();
        test_zero_max_echo();
        test_register_extremes();

        test_random_traffic(12, 83, 430);
        test_random_traffic(83, 12, 430);
        test_random_traffic(0, 0, 440);

        wait_results_drained();
        repeat (RING_SIZE + 8) @(posedge i_clk);
        if (mismatches == 0 && expected_status_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: ultrasonic_echo_ranger.f
sv/uer_pkg.sv
sv/uer_ram.sv
sv/uer_ctrl.sv
sv/ultrasonic_echo_ranger.sv
sv/uer_chk.sv
bench/ultrasonic_echo_ranger_tb.sv
